FILE: rtl/fdtw_pkg.sv
package fdtw_pkg;

   localparam int WORD_W            = 32;
   localparam int EVENT_W           = 3;
   localparam int ERROR_W           = 2;
   localparam int DEPTH_W           = 5;
   localparam int MODE_W            = 3;
   localparam int VCOUNT_W          = 30;
   localparam int CSR_INDEX_W       = 1;
   localparam int MAX_DEPTH_DEFAULT = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_STRUCT_SIZE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRINGS_BASE = 1'd1;

   localparam logic [WORD_W-1:0] TOK_BEGIN = 32'h0000_0001;
   localparam logic [WORD_W-1:0] TOK_ENDN  = 32'h0000_0002;
   localparam logic [WORD_W-1:0] TOK_PROP  = 32'h0000_0003;
   localparam logic [WORD_W-1:0] TOK_NOP   = 32'h0000_0004;
   localparam logic [WORD_W-1:0] TOK_END   = 32'h0000_0009;

   localparam logic [MODE_W-1:0] M_TOP   = 3'd0;
   localparam logic [MODE_W-1:0] M_NAME  = 3'd1;
   localparam logic [MODE_W-1:0] M_BODY  = 3'd2;
   localparam logic [MODE_W-1:0] M_PLEN  = 3'd3;
   localparam logic [MODE_W-1:0] M_PNAME = 3'd4;
   localparam logic [MODE_W-1:0] M_VALUE = 3'd5;
   localparam logic [MODE_W-1:0] M_DONE  = 3'd6;

   localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
   localparam logic [EVENT_W-1:0] EV_BEGIN = 3'd1;
   localparam logic [EVENT_W-1:0] EV_END   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_PROP  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_FIN   = 3'd4;
   localparam logic [EVENT_W-1:0] EV_ERR   = 3'd5;

   localparam logic [ERROR_W-1:0] ERR_TOKEN   = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_OVERRUN = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_DEPTH   = 2'd2;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [ERROR_W-1:0] error_kind;
      logic [DEPTH_W-1:0] depth;
      logic [WORD_W-1:0]  node_name_offset;
      logic [WORD_W-1:0]  prop_name_addr;
      logic [WORD_W-1:0]  value_len;
      logic [WORD_W-1:0]  value_offset;
   } rsp_type;

endpackage

FILE: rtl/fdtw_req_if.sv
interface fdtw_req_if;
   import fdtw_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic              start_of_block;

   modport source (output valid, output word, output start_of_block, input ready);
   modport sink (input valid, input word, input start_of_block, output ready);

endinterface

FILE: rtl/fdtw_rsp_if.sv
interface fdtw_rsp_if;
   import fdtw_pkg::*;

   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_res;
   logic [ERROR_W-1:0] error_kind;
   logic [DEPTH_W-1:0] depth;
   logic [WORD_W-1:0]  node_name_offset;
   logic [WORD_W-1:0]  prop_name_addr;
   logic [WORD_W-1:0]  value_len;
   logic [WORD_W-1:0]  value_offset;

   modport source (
      output valid, output event_res, output error_kind, output depth,
      output node_name_offset, output prop_name_addr, output value_len,
      output value_offset, input ready
   );
   modport sink (
      input valid, input event_res, input error_kind, input depth,
      input node_name_offset, input prop_name_addr, input value_len,
      input value_offset, output ready
   );

endinterface

FILE: rtl/fdtw_ram.sv
module fdtw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/fdtw_skid.sv
module fdtw_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fdtw_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fdtw_pkg::rsp_type out_data
);
   import fdtw_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    out_fire;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign out_fire  = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (out_fire && skid_valid_ff) begin
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end else if (in_valid && in_ready) begin
         if (!main_valid_ff || out_ready) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: rtl/flattened_device_tree_walker_top.sv
// a result item is registered in the output skid: its main register, or its skid register under a stall
// throughput: one word per cycle while the output skid has room; the parse state and the top-of-stack register
// update in the accepting cycle, the name stack RAM prefetches the entry below
// a two-entry output skid: with the result side stalled one more word is taken, then ready drops
// reset (synchronous, active high) clears the parse state, the CSR registers and valids;
// the top-of-stack register, the skid data registers and the name stack RAM are not cleared
module flattened_device_tree_walker_top #(
   parameter int MAX_DEPTH = fdtw_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   fdtw_req_if.sink                         req_ch,
   fdtw_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [fdtw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fdtw_pkg::WORD_W-1:0]      csr_wdata
);
   import fdtw_pkg::*;

   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [WORD_W-1:0]   offset_ff, offset_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [VCOUNT_W-1:0] vwl_ff, vwl_in;
   logic [WORD_W-1:0]   plen_ff, plen_in;
   logic [WORD_W-1:0]   tos_ff, tos_in;
   logic [WORD_W-1:0]   size_ff, size_in;
   logic [WORD_W-1:0]   base_ff, base_in;

   logic                accept;
   logic                skid_ready;
   rsp_type             rsp_data;
   rsp_type             out_data;

   logic [MODE_W-1:0]   cur_mode;
   logic [WORD_W-1:0]   cur_off;
   logic [DW-1:0]       cur_depth;
   logic [VCOUNT_W-1:0] cur_vwl;
   logic [WORD_W-1:0]   next_off;
   logic                past_size;
   logic                has_zero;
   logic [WORD_W:0]     padded_len;
   logic [WORD_W-2:0]   pad_words;
   logic [WORD_W-2:0]   pad_words_m1;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [DW-1:0]       raddr_wide;
   logic [WORD_W-1:0]   below;

   assign accept = req_ch.valid && skid_ready;
   assign req_ch.ready = skid_ready;

   always_comb begin
      size_in = size_ff;
      base_in = base_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STRUCT_SIZE:  size_in = csr_wdata;
            CSR_STRINGS_BASE: base_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cur_mode  = req_ch.start_of_block ? M_TOP : mode_ff;
      cur_off   = req_ch.start_of_block ? '0 : offset_ff;
      cur_depth = req_ch.start_of_block ? '0 : depth_ff;
      cur_vwl   = req_ch.start_of_block ? '0 : vwl_ff;
      plen_in   = req_ch.start_of_block ? '0 : plen_ff;
      next_off  = cur_off + 32'd4;
      past_size = cur_off >= size_ff;
      has_zero  = (req_ch.word[31:24] == 8'd0) || (req_ch.word[23:16] == 8'd0) ||
                  (req_ch.word[15:8] == 8'd0) || (req_ch.word[7:0] == 8'd0);
      padded_len   = {1'b0, plen_ff} + 33'd3;
      pad_words    = padded_len[WORD_W:2];
      pad_words_m1 = pad_words - 31'd1;

      mode_in   = cur_mode;
      depth_in  = cur_depth;
      vwl_in    = cur_vwl;
      tos_in    = tos_ff;
      mem_we    = 1'b0;
      mem_waddr = cur_depth[AW-1:0];
      rsp_data  = '0;

      unique case (cur_mode)
         M_TOP: begin
            if (past_size || req_ch.word == TOK_END) begin
               rsp_data.event_res = EV_FIN;
               mode_in = M_DONE;
            end else if (req_ch.word == TOK_BEGIN) begin
               if (cur_depth >= DEPTH_LIMIT) begin
                  rsp_data.event_res  = EV_ERR;
                  rsp_data.error_kind = ERR_DEPTH;
                  mode_in = M_DONE;
               end else begin
                  mem_we   = 1'b1;
                  tos_in   = next_off;
                  depth_in = cur_depth + DW'(1);
                  rsp_data.event_res        = EV_BEGIN;
                  rsp_data.node_name_offset = next_off;
                  mode_in = M_NAME;
               end
            end else if (req_ch.word != TOK_NOP) begin
               rsp_data.event_res  = EV_ERR;
               rsp_data.error_kind = ERR_TOKEN;
               mode_in = M_DONE;
            end
         end
         M_DONE: ;
         M_NAME, M_BODY, M_PLEN, M_PNAME, M_VALUE: begin
            if (past_size) begin
               rsp_data.event_res  = EV_ERR;
               rsp_data.error_kind = ERR_OVERRUN;
               mode_in = M_DONE;
            end else begin
               case (cur_mode)
                  M_NAME: begin
                     if (has_zero) begin
                        mode_in = M_BODY;
                     end
                  end
                  M_BODY: begin
                     if (req_ch.word == TOK_BEGIN) begin
                        if (cur_depth >= DEPTH_LIMIT) begin
                           rsp_data.event_res  = EV_ERR;
                           rsp_data.error_kind = ERR_DEPTH;
                           mode_in = M_DONE;
                        end else begin
                           mem_we   = 1'b1;
                           tos_in   = next_off;
                           depth_in = cur_depth + DW'(1);
                           rsp_data.event_res        = EV_BEGIN;
                           rsp_data.node_name_offset = next_off;
                           mode_in = M_NAME;
                        end
                     end else if (req_ch.word == TOK_ENDN) begin
                        rsp_data.event_res = EV_END;
                        if (cur_depth != '0) begin
                           rsp_data.node_name_offset = tos_ff;
                           depth_in = cur_depth - DW'(1);
                           tos_in   = below;
                        end
                        mode_in = (depth_in == '0) ? M_TOP : M_BODY;
                     end else if (req_ch.word == TOK_PROP) begin
                        mode_in = M_PLEN;
                     end else if (req_ch.word != TOK_NOP) begin
                        rsp_data.event_res  = EV_ERR;
                        rsp_data.error_kind = ERR_TOKEN;
                        mode_in = M_DONE;
                     end
                  end
                  M_PLEN: begin
                     plen_in = req_ch.word;
                     mode_in = M_PNAME;
                  end
                  M_PNAME: begin
                     rsp_data.event_res      = EV_PROP;
                     rsp_data.prop_name_addr = base_ff + req_ch.word;
                     rsp_data.value_len      = plen_ff;
                     rsp_data.value_offset   = next_off;
                     if (cur_depth != '0) begin
                        rsp_data.node_name_offset = tos_ff;
                     end
                     if (pad_words == '0) begin
                        mode_in = M_BODY;
                     end else begin
                        vwl_in  = pad_words_m1[VCOUNT_W-1:0];
                        mode_in = M_VALUE;
                     end
                  end
                  default: begin
                     if (cur_vwl == '0) begin
                        mode_in = M_BODY;
                     end else begin
                        vwl_in = cur_vwl - 30'd1;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase

      rsp_data.depth = DEPTH_W'(depth_in);
      offset_in = next_off;

      if (!accept) begin
         mode_in   = mode_ff;
         offset_in = offset_ff;
         depth_in  = depth_ff;
         vwl_in    = vwl_ff;
         plen_in   = plen_ff;
         tos_in    = tos_ff;
         mem_we    = 1'b0;
      end
      raddr_wide = depth_in - DW'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_TOP;
         offset_ff <= '0;
         depth_ff  <= '0;
         vwl_ff    <= '0;
         plen_ff   <= '0;
         size_ff   <= '0;
         base_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         depth_ff  <= depth_in;
         vwl_ff    <= vwl_in;
         plen_ff   <= plen_in;
         size_ff   <= size_in;
         base_ff   <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   fdtw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_DEPTH)
   ) u_name_stack (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (next_off),
      .raddr (raddr_wide[AW-1:0]),
      .rdata (below)
   );

   fdtw_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (skid_ready),
      .in_data   (rsp_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.event_res        = out_data.event_res;
   assign rsp_ch.error_kind       = out_data.error_kind;
   assign rsp_ch.depth            = out_data.depth;
   assign rsp_ch.node_name_offset = out_data.node_name_offset;
   assign rsp_ch.prop_name_addr   = out_data.prop_name_addr;
   assign rsp_ch.value_len        = out_data.value_len;
   assign rsp_ch.value_offset     = out_data.value_offset;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import fdtw_pkg::*;

   localparam int NEST_LIMIT = MAX_DEPTH_DEFAULT;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0] csr_wdata;

   fdtw_req_if req_ch ();
   fdtw_rsp_if rsp_ch ();

   flattened_device_tree_walker_top #(.MAX_DEPTH(NEST_LIMIT)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // walker copy used to predict each result item
   logic [WORD_W-1:0]   cfg_struct_size = '0;
   logic [WORD_W-1:0]   cfg_strings_base = '0;
   logic [MODE_W-1:0]   walk_mode = M_TOP;
   logic [WORD_W-1:0]   walk_offset = '0;
   logic [DEPTH_W-1:0]  walk_depth = '0;
   logic [WORD_W-1:0]   walk_names [NEST_LIMIT];
   logic [VCOUNT_W-1:0] walk_value_left = '0;
   logic [WORD_W-1:0]   walk_pend_len = '0;

   rsp_type due_events [$];
   rsp_type head_event;
   int fail_count = 0;
   int words_sent = 0;
   bit steady = 1'b0;

   function automatic rsp_type walk_word(input logic [WORD_W-1:0] w, input logic sob);
      rsp_type r;
      logic [WORD_W-1:0] off;
      logic [WORD_W:0] words;
      bit opening;
      r = '0;
      opening = 1'b0;
      if (sob) begin
         walk_mode = M_TOP;
         walk_offset = '0;
         walk_depth = '0;
         walk_value_left = '0;
         walk_pend_len = '0;
      end
      off = walk_offset;
      if (walk_mode == M_TOP) begin
         if (off >= cfg_struct_size || w == TOK_END) begin
            r.event_res = EV_FIN;
            walk_mode = M_DONE;
         end else if (w == TOK_BEGIN) begin
            opening = 1'b1;
         end else if (w != TOK_NOP) begin
            r.event_res = EV_ERR;
            r.error_kind = ERR_TOKEN;
            walk_mode = M_DONE;
         end
      end else if (walk_mode != M_DONE && off >= cfg_struct_size) begin
         r.event_res = EV_ERR;
         r.error_kind = ERR_OVERRUN;
         walk_mode = M_DONE;
      end else begin
         case (walk_mode)
            M_NAME: begin
               if (w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 ||
                   w[7:0] == 8'h00)
                  walk_mode = M_BODY;
            end
            M_BODY: begin
               if (w == TOK_BEGIN) begin
                  opening = 1'b1;
               end else if (w == TOK_ENDN) begin
                  r.event_res = EV_END;
                  if (walk_depth != 0) begin
                     r.node_name_offset = walk_names[walk_depth - 1];
                     walk_depth = walk_depth - 1'b1;
                  end
                  walk_mode = (walk_depth == 0) ? M_TOP : M_BODY;
               end else if (w == TOK_PROP) begin
                  walk_mode = M_PLEN;
               end else if (w != TOK_NOP) begin
                  r.event_res = EV_ERR;
                  r.error_kind = ERR_TOKEN;
                  walk_mode = M_DONE;
               end
            end
            M_PLEN: begin
               walk_pend_len = w;
               walk_mode = M_PNAME;
            end
            M_PNAME: begin
               words = ({1'b0, walk_pend_len} + 33'd3) >> 2;
               r.event_res = EV_PROP;
               if (walk_depth != 0) r.node_name_offset = walk_names[walk_depth - 1];
               r.prop_name_addr = cfg_strings_base + w;
               r.value_len = walk_pend_len;
               r.value_offset = off + 32'd4;
               if (words == 0) begin
                  walk_mode = M_BODY;
               end else begin
                  words = words - 1'b1;
                  walk_value_left = words[VCOUNT_W-1:0];
                  walk_mode = M_VALUE;
               end
            end
            M_VALUE: begin
               if (walk_value_left == 0) walk_mode = M_BODY;
               else walk_value_left = walk_value_left - 1'b1;
            end
            default: ;
         endcase
      end
      if (opening) begin
         if (walk_depth >= NEST_LIMIT) begin
            r.event_res = EV_ERR;
            r.error_kind = ERR_DEPTH;
            walk_mode = M_DONE;
         end else begin
            walk_names[walk_depth] = off + 32'd4;
            walk_depth = walk_depth + 1'b1;
            r.event_res = EV_BEGIN;
            r.node_name_offset = off + 32'd4;
            walk_mode = M_NAME;
         end
      end
      walk_offset = off + 32'd4;
      r.depth = walk_depth;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_v,
                                       input logic [WORD_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   function automatic logic [WORD_W-1:0] name_word(input bit last);
      logic [WORD_W-1:0] w;
      int i;
      for (i = 0; i < 4; i++) w[8*i +: 8] = 8'($urandom_range(1, 255));
      if (last) w[8*$urandom_range(0, 3) +: 8] = 8'h00;
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] noise_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 4))
         0: w = $urandom;
         1: w = TOK_END;
         2: w = TOK_ENDN;
         3: w = TOK_PROP;
         default: w = $urandom_range(0, 15);
      endcase
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] value_length(input bit closing);
      int r;
      logic [WORD_W-1:0] len;
      r = $urandom_range(0, 99);
      if (closing || r < 60) len = $urandom_range(0, 16);
      else if (r < 85) len = $urandom_range(17, 64);
      else if (r < 93) len = $urandom_range(65, 256);
      else if (r < 97) len = $urandom;
      else len = 32'hFFFF_FFFF - $urandom_range(0, 4);
      return len;
   endfunction

   task automatic send_word(input logic [WORD_W-1:0] w, input logic sob);
      while (!steady && $urandom_range(0, 99) < 18) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.word <= w;
      req_ch.start_of_block <= sob;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      due_events.push_back(walk_word(w, sob));
      words_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (due_events.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_config(input logic [WORD_W-1:0] size, input logic [WORD_W-1:0] base);
      csr_we <= 1'b1;
      csr_index <= CSR_STRUCT_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      csr_index <= CSR_STRINGS_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_struct_size = size;
      cfg_strings_base = base;
   endtask

   // one structure block whose next token follows the walker's current mode
   task automatic send_walk(input int steps, input int max_nest, input int open_pct,
                            input int noise_pct);
      int k;
      int r;
      bit closing;
      logic sob;
      logic [WORD_W-1:0] w;
      k = 0;
      send_word(($urandom_range(0, 3) == 0) ? TOK_NOP : TOK_BEGIN, 1'b1);
      while (walk_mode != M_DONE && k < steps + 48) begin
         closing = (k >= steps);
         r = $urandom_range(0, 99);
         sob = !closing && $urandom_range(0, 99) == 0;
         case (walk_mode)
            M_TOP: begin
               if (closing) w = TOK_END;
               else if (r < noise_pct) w = noise_word();
               else if (r < 75) w = TOK_BEGIN;
               else if (r < 90) w = TOK_NOP;
               else w = TOK_END;
            end
            M_NAME: w = name_word(closing || r < 55);
            M_BODY: begin
               if (closing) begin
                  w = TOK_ENDN;
               end else if (r < noise_pct) begin
                  w = noise_word();
               end else if ($urandom_range(0, 99) < open_pct && walk_depth < max_nest) begin
                  w = TOK_BEGIN;
               end else begin
                  r = $urandom_range(0, 9);
                  w = (r < 3) ? TOK_ENDN : (r < 8) ? TOK_PROP : TOK_NOP;
               end
            end
            M_PLEN: w = value_length(closing);
            M_PNAME: w = (r < 50) ? $urandom_range(0, 255) : $urandom;
            default: w = $urandom;
         endcase
         send_word(w, sob);
         k++;
      end
      if ($urandom_range(0, 3) == 0) send_word($urandom, 1'b0);
   endtask

   task automatic test_directed_tokens();
      // reset size of zero: first word already past the block
      send_word(TOK_BEGIN, 1'b1);
      settle();
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFF0);
      send_word(TOK_NOP, 1'b1);
      send_word(TOK_BEGIN, 1'b0);
      send_word(32'h4142_4300, 1'b0);
      send_word(TOK_PROP, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0020, 1'b0);
      send_word(TOK_PROP, 1'b0);
      send_word(32'h0000_0005, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(TOK_BEGIN, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(TOK_ENDN, 1'b0);
      send_word(TOK_END, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      // tokens not allowed at top level, then an end token there
      send_word(TOK_ENDN, 1'b1);
      send_word(TOK_PROP, 1'b1);
      send_word(TOK_END, 1'b1);
   endtask

   task automatic test_size_limit();
      settle();
      set_config(32'd12, 32'h0000_0000);
      send_word(TOK_BEGIN, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(TOK_ENDN, 1'b0);
      send_word(TOK_BEGIN, 1'b0);
      send_word(TOK_BEGIN, 1'b1);
      send_word(32'h0101_0101, 1'b0);
      send_word(32'h7F7F_7F7F, 1'b0);
      send_word(TOK_ENDN, 1'b0);
   endtask

   task automatic test_deep_nesting();
      settle();
      set_config(32'hFFFF_FFFF, $urandom);
      repeat (2) send_walk(80, NEST_LIMIT, 90, 0);
      repeat (2) send_walk(80, NEST_LIMIT + 1, 90, 0);
   endtask

   task automatic test_random_walks();
      int ph;
      int first;
      int budget;
      int noise;
      for (ph = 0; ph < 8; ph++) begin
         settle();
         budget = 120;
         noise = 4;
         case (ph)
            0: set_config(32'hFFFF_FFFF, 32'h0000_0000);
            1: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: set_config($urandom_range(16, 400), $urandom);
            3: set_config(32'hFFFF_FFFF, $urandom);
            4: begin
               set_config(32'h0000_0000, $urandom);
               budget = 20;
            end
            5: set_config($urandom_range(4, 64), $urandom);
            6: set_config(32'h8000_0000, 32'h8000_0000);
            default: begin
               set_config(32'hFFFF_FFFF, $urandom);
               noise = 15;
            end
         endcase
         steady = (ph == 3);
         first = words_sent;
         while (words_sent - first < budget)
            send_walk($urandom_range(10, 60),
                      ($urandom_range(0, 9) == 0) ? NEST_LIMIT + 1 : $urandom_range(1, 4),
                      20, noise);
         steady = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 18);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_events.size() == 0) begin
            $error("result item with none due: event_res %0d", rsp_ch.event_res);
            fail_count++;
         end else begin
            head_event = due_events.pop_front();
            check_field("event_res", WORD_W'(head_event.event_res),
                        WORD_W'(rsp_ch.event_res));
            check_field("error_kind", WORD_W'(head_event.error_kind),
                        WORD_W'(rsp_ch.error_kind));
            check_field("depth", WORD_W'(head_event.depth), WORD_W'(rsp_ch.depth));
            check_field("node_name_offset", head_event.node_name_offset,
                        rsp_ch.node_name_offset);
            check_field("prop_name_addr", head_event.prop_name_addr, rsp_ch.prop_name_addr);
            check_field("value_len", head_event.value_len, rsp_ch.value_len);
            check_field("value_offset", head_event.value_offset, rsp_ch.value_offset);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.word <= '0;
      req_ch.start_of_block <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_STRUCT_SIZE;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_tokens();
      test_size_limit();
      test_deep_nesting();
      test_random_walks();
      req_ch.valid <= 1'b0;
      while (due_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
